// File: rtl/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg: shared definitions of the Cartesian/polar point register
// Operation codes, datapath widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // Operation codes carried by in_operation.
  localparam logic [2:0] OP_LOAD_XY    = 3'd0;
  localparam logic [2:0] OP_SET_X      = 3'd1;
  localparam logic [2:0] OP_SET_Y      = 3'd2;
  localparam logic [2:0] OP_SET_RADIUS = 3'd3;
  localparam logic [2:0] OP_SET_ANGLE  = 3'd4;

  // Default number of CORDIC micro-rotations.
  localparam int ROTATION_STEPS_DEF = 16;

  // CORDIC coordinate width: Q16.16 with 16 guard bits plus gain headroom.
  localparam int CORDIC_W = 52;
  // Angle accumulator width: 32-bit turn fraction plus sign and headroom.
  localparam int ZACC_W = 34;
  // Width of the arctangent table index.
  localparam int TURN_IDX_W = 5;

  // Inverse CORDIC gain as a 0.32 fraction.
  localparam logic [31:0] GAIN_INV_Q32 = 32'd2608131496;
  // Half a turn in the 32-bit angle format.
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Arctangent of 2^-i as a 32-bit fraction of a full turn.
  function automatic logic [31:0] atan_turn(input logic [TURN_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      5'd30:   val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/cpr_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_rotator: one CORDIC micro-rotation
// Shared shift-add unit used for every step of both vectoring and rotation.
// ----------------------------------------------------------------------------
module cpr_rotator (
  input  logic signed [cpr_pkg::CORDIC_W-1:0]   x_i,
  input  logic signed [cpr_pkg::CORDIC_W-1:0]   y_i,
  input  logic signed [cpr_pkg::ZACC_W-1:0]     z_i,
  input  logic                                  vectoring_i,
  input  logic        [cpr_pkg::TURN_IDX_W-1:0] step_i,
  output logic signed [cpr_pkg::CORDIC_W-1:0]   x_o,
  output logic signed [cpr_pkg::CORDIC_W-1:0]   y_o,
  output logic signed [cpr_pkg::ZACC_W-1:0]     z_o
);

  logic signed [cpr_pkg::CORDIC_W-1:0] x_sh;
  logic signed [cpr_pkg::CORDIC_W-1:0] y_sh;
  logic signed [cpr_pkg::ZACC_W-1:0]   atan_z;
  logic                                turn_up;

  // Arithmetic (floor) shifts of both coordinates by the step index.
  assign x_sh = x_i >>> step_i;
  assign y_sh = y_i >>> step_i;

  assign atan_z = $signed({{(cpr_pkg::ZACC_W-32){1'b0}}, cpr_pkg::atan_turn(step_i)});

  // Vectoring drives y toward zero; rotation drives the residual angle to zero.
  // Both cases reduce to one direction bit.
  assign turn_up = vectoring_i ? ~y_i[cpr_pkg::CORDIC_W-1] : z_i[cpr_pkg::ZACC_W-1];

  always_comb begin
    if (turn_up) begin
      x_o = x_i + y_sh;
      y_o = y_i - x_sh;
      z_o = z_i + atan_z;
    end else begin
      x_o = x_i - y_sh;
      y_o = y_i + x_sh;
      z_o = z_i - atan_z;
    end
  end

endmodule

// File: rtl/cartesian_polar_point_register_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_polar_point_register_unit: point held in Cartesian and polar form
// Keeps x, y, radius and angle consistent with a shared CORDIC unit.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. It carries
//   an operation and the new x, y, radius or angle that the operation uses.
//   Changing x or y runs a vectoring pass that recomputes radius and angle;
//   changing radius or angle runs a rotation pass that recomputes x and y.
//   Each item gives one result: out_valid is high for exactly one cycle and
//   out_x_out, out_y_out, out_radius_out and out_angle_out show the point.
//   The receiver cannot stall; the strobe must be taken when it appears.
//   Points on an axis, angles on an axis and unused operations are answered
//   straight from the idle state without a CORDIC pass. A vectoring pass
//   runs ROTATION_STEPS micro-rotations at one per cycle in the CORDIC loop,
//   then a gain correction of the radius; a rotation pass does the same and
//   corrects x and then y. The gain correction shares one 32x32 multiplier
//   and steps through S_ABS, S_MLO, S_MHI and S_ACC for each coordinate.
//   busy is low during the strobe cycle, so the next item may be taken
//   then.
// Reset clears the point to the origin with angle zero and drops busy.
// ----------------------------------------------------------------------------
module cartesian_polar_point_register_unit #(
  parameter int ROTATION_STEPS = cpr_pkg::ROTATION_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [2:0]  in_operation,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  input  logic signed [31:0] in_radius_in,
  input  logic        [15:0] in_angle_in,
  output logic               out_valid,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [31:0] out_radius_out,
  output logic        [15:0] out_angle_out
);

  localparam int CW = cpr_pkg::CORDIC_W;
  localparam int ZW = cpr_pkg::ZACC_W;
  localparam int IW = $clog2(ROTATION_STEPS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ITER = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;

  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  // Magnitude of a 32-bit value, saturated at the largest positive value.
  function automatic logic [31:0] abs_sat32(input logic [31:0] a);
    logic [31:0] res;
    if (a == INT_MIN) begin
      res = INT_MAX;
    end else if (a[31]) begin
      res = -a;
    end else begin
      res = a;
    end
    return res;
  endfunction

  // Negation of a 32-bit value, saturated at the largest positive value.
  function automatic logic [31:0] neg_sat32(input logic [31:0] a);
    logic [31:0] res;
    if (a == INT_MIN) begin
      res = INT_MAX;
    end else begin
      res = -a;
    end
    return res;
  endfunction

  // Q16.16 value scaled by the guard bits and sign-extended to the datapath.
  function automatic logic signed [CW-1:0] widen(input logic [31:0] a);
    return $signed({{(CW-48){a[31]}}, a, 16'b0});
  endfunction

  // Architectural point.
  logic signed [31:0] coord_x_r;
  logic signed [31:0] coord_y_r;
  logic signed [31:0] radius_r;
  logic        [15:0] angle_r;

  // Sequencer and datapath registers.
  logic [2:0]           state_r;
  logic [IW-1:0]        cnt_r;
  logic                 out_valid_r;
  logic                 rot_r;
  logic                 sel_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic [CW-1:0]        mag_r;
  logic                 neg_r;
  logic [63:0]          prod_r;
  logic [32:0]          lo_rnd_r;

  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;

  // Item decode and the values the point takes once the item is applied.
  logic               accept;
  logic               do_polar;
  logic               do_cart;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_r;
  logic        [15:0] new_a;
  logic        [1:0]  quad;
  logic               flip;
  logic signed [CW-1:0] r_wide;
  logic signed [CW-1:0] x_wide;
  logic signed [CW-1:0] y_wide;
  logic [31:0]          z_cart;

  // Gain correction datapath.
  logic signed [CW-1:0] corr_src;
  logic [31:0]          mul_a;
  logic [63:0]          mul_p;
  logic [64:0]          lo_sum;
  logic [64:0]          acc_sum;
  logic [48:0]          mag_q;
  logic [31:0]          corr_res;
  logic [31:0]          z_round;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    do_polar = 1'b0;
    do_cart  = 1'b0;
    unique case (in_operation) inside
      cpr_pkg::OP_LOAD_XY, cpr_pkg::OP_SET_X, cpr_pkg::OP_SET_Y: begin
        do_polar = 1'b1;
      end
      cpr_pkg::OP_SET_RADIUS, cpr_pkg::OP_SET_ANGLE: begin
        do_cart = 1'b1;
      end
      default: begin
        do_polar = 1'b0;
      end
    endcase
  end

  assign new_x = (in_operation == cpr_pkg::OP_LOAD_XY || in_operation == cpr_pkg::OP_SET_X)
                 ? in_x_in : coord_x_r;
  assign new_y = (in_operation == cpr_pkg::OP_LOAD_XY || in_operation == cpr_pkg::OP_SET_Y)
                 ? in_y_in : coord_y_r;
  assign new_r = (in_operation == cpr_pkg::OP_SET_RADIUS) ? in_radius_in : radius_r;
  assign new_a = (in_operation == cpr_pkg::OP_SET_ANGLE) ? in_angle_in : angle_r;

  // Starting vectors of both passes; the left half-plane is folded over.
  assign quad   = new_a[15:14];
  assign flip   = (quad == 2'd1) || (quad == 2'd2);
  assign x_wide = widen(new_x);
  assign y_wide = widen(new_y);
  assign r_wide = widen(new_r);
  assign z_cart = {new_a, 16'b0} + (flip ? cpr_pkg::HALF_TURN : 32'd0);

  // Shared micro-rotation unit.
  cpr_rotator u_rotator (
    .x_i         (x_r),
    .y_i         (y_r),
    .z_i         (z_r),
    .vectoring_i (~rot_r),
    .step_i      (cpr_pkg::TURN_IDX_W'(cnt_r)),
    .x_o         (x_nxt),
    .y_o         (y_nxt),
    .z_o         (z_nxt)
  );

  // One 32x32 multiplier takes the low and then the high half of the magnitude.
  assign corr_src = sel_r ? y_r : x_r;
  assign mul_a    = (state_r == S_MLO) ? mag_r[31:0] : 32'(mag_r[CW-1:32]);
  assign mul_p    = {32'b0, mul_a} * {32'b0, cpr_pkg::GAIN_INV_Q32};
  assign lo_sum   = {1'b0, prod_r} + 65'h0_8000_0000;

  // High product plus rounded low product, then the guard bits are rounded off.
  assign acc_sum = {1'b0, prod_r} + {32'b0, lo_rnd_r} + 65'h8000;
  assign mag_q   = acc_sum[64:16];

  // Sign is restored and the result saturated to 32 bits.
  always_comb begin
    if (neg_r) begin
      if (mag_q > 49'h0_8000_0000) begin
        corr_res = INT_MIN;
      end else begin
        corr_res = -mag_q[31:0];
      end
    end else begin
      if (mag_q > 49'h0_7FFF_FFFF) begin
        corr_res = INT_MAX;
      end else begin
        corr_res = mag_q[31:0];
      end
    end
  end

  assign z_round = z_r[31:0] + 32'h8000;

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rot_r       <= 1'b0;
      sel_r       <= 1'b0;
      coord_x_r   <= '0;
      coord_y_r   <= '0;
      radius_r    <= '0;
      angle_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            coord_x_r <= new_x;
            coord_y_r <= new_y;
            radius_r  <= new_r;
            angle_r   <= new_a;
            cnt_r     <= '0;
            sel_r     <= 1'b0;
            if (do_polar) begin
              rot_r <= 1'b0;
              if (new_x == 32'sd0 && new_y == 32'sd0) begin
                // Origin.
                radius_r    <= '0;
                angle_r     <= '0;
                out_valid_r <= 1'b1;
              end else if (new_y == 32'sd0) begin
                // Point on the x axis.
                radius_r    <= abs_sat32(new_x);
                angle_r     <= new_x[31] ? 16'h8000 : 16'h0000;
                out_valid_r <= 1'b1;
              end else if (new_x == 32'sd0) begin
                // Point on the y axis.
                radius_r    <= abs_sat32(new_y);
                angle_r     <= new_y[31] ? 16'hC000 : 16'h4000;
                out_valid_r <= 1'b1;
              end else begin
                x_r     <= new_x[31] ? -x_wide : x_wide;
                y_r     <= new_x[31] ? -y_wide : y_wide;
                z_r     <= new_x[31] ? ZW'(cpr_pkg::HALF_TURN) : '0;
                state_r <= S_ITER;
              end
            end else if (do_cart) begin
              rot_r <= 1'b1;
              if (new_a[13:0] == 14'd0) begin
                // Angle on an axis: exact result.
                unique case (quad)
                  2'd0: begin
                    coord_x_r <= new_r;
                    coord_y_r <= '0;
                  end
                  2'd1: begin
                    coord_x_r <= '0;
                    coord_y_r <= new_r;
                  end
                  2'd2: begin
                    coord_x_r <= neg_sat32(new_r);
                    coord_y_r <= '0;
                  end
                  default: begin
                    coord_x_r <= '0;
                    coord_y_r <= neg_sat32(new_r);
                  end
                endcase
                out_valid_r <= 1'b1;
              end else begin
                x_r     <= flip ? -r_wide : r_wide;
                y_r     <= '0;
                z_r     <= $signed({{(ZW-32){z_cart[31]}}, z_cart});
                state_r <= S_ITER;
              end
            end else begin
              // Unused operation code: the point is returned unchanged.
              out_valid_r <= 1'b1;
            end
          end
        end
        S_ITER: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IW'(ROTATION_STEPS - 1)) begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          mag_r   <= corr_src[CW-1] ? unsigned'(-corr_src) : unsigned'(corr_src);
          neg_r   <= corr_src[CW-1];
          state_r <= S_MLO;
        end
        S_MLO: begin
          prod_r  <= mul_p;
          state_r <= S_MHI;
        end
        S_MHI: begin
          lo_rnd_r <= lo_sum[64:32];
          prod_r   <= mul_p;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          if (!rot_r) begin
            radius_r    <= corr_res;
            angle_r     <= z_round[31:16];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (!sel_r) begin
            coord_x_r <= corr_res;
            sel_r     <= 1'b1;
            state_r   <= S_ABS;
          end else begin
            coord_y_r   <= corr_res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_x_out      = coord_x_r;
  assign out_y_out      = coord_y_r;
  assign out_radius_out = radius_r;
  assign out_angle_out  = angle_r;

endmodule

// File: rtl/cpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_checker: port-level checks of the point register
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module cpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic        [2:0]  in_operation,
  input logic               out_valid,
  input logic signed [31:0] out_x_out,
  input logic signed [31:0] out_y_out,
  input logic signed [31:0] out_radius_out,
  input logic        [15:0] out_angle_out
);

  // A result is only shown once the block has finished its work.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted item either starts a pass or is answered in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither started nor answered");

  // The block only goes busy because an item was taken.
  assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
    else $error("busy without an accepted item");

  // The end of every pass delivers a result.
  assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> out_valid)
    else $error("pass ended without a result");

  // An unused operation code returns the point unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation > cpr_pkg::OP_SET_ANGLE) |=>
      (out_valid && $stable(out_x_out) && $stable(out_y_out) &&
       $stable(out_radius_out) && $stable(out_angle_out)))
    else $error("unused operation changed the point");

endmodule

bind cartesian_polar_point_register_unit cpr_checker u_cpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_x_out      (out_x_out),
  .out_y_out      (out_y_out),
  .out_radius_out (out_radius_out),
  .out_angle_out  (out_angle_out)
);
